// File: src/scbp_pkg.sv
package scbp_pkg;

   localparam int SLOT_COUNT    = 16;
   localparam int SLOT_IDX_W    = $clog2(SLOT_COUNT);
   localparam int MAX_SIZE_LOG2 = 24;
   localparam int LOG2_W        = 5;
   localparam int COUNT_W       = 25;
   localparam int HANDLE_W      = 4;
   localparam int SLOT_OUT_W    = 4;
   localparam int DEV_W         = 2;
   localparam int TYPE_W        = 4;
   localparam int STATUS_W      = 2;
   localparam int GROUP_COUNT   = (COUNT_W + 7) / 8;
   localparam int GRP_W         = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int PAD_W         = GROUP_COUNT * 8;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd2;

   localparam logic ACT_REQUEST = 1'b0;
   localparam logic ACT_RETURN  = 1'b1;

   typedef struct packed {
      logic load;
      logic round_step;
      logic scan_issue;
      logic ret_read;
      logic ret_commit;
      logic req_commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_return;
      logic round_done;
      logic scan_last;
   } dp_status_type;

   typedef struct packed {
      logic [DEV_W-1:0]  device;
      logic [TYPE_W-1:0] elem_type;
      logic [LOG2_W-1:0] size_log2;
   } slot_entry_type;

endpackage

// File: src/scbp_ctrl.sv
module scbp_ctrl
   import scbp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ROUND  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_FINISH = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;
   localparam logic [2:0] S_RET    = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            if (status.is_return) begin
               cmd.ret_read = 1'b1;
               state_in     = S_RET;
            end else begin
               cmd.round_step = 1'b1;
               if (status.round_done) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.req_commit = 1'b1;
            state_in       = S_IDLE;
         end
         S_RET: begin
            cmd.ret_commit = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: src/scbp_datapath.sv
module scbp_datapath
   import scbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   input  logic                  req_action,
   input  logic [DEV_W-1:0]      req_device_kind,
   input  logic [TYPE_W-1:0]     req_element_type,
   input  logic [COUNT_W-1:0]    req_element_count,
   input  logic [HANDLE_W-1:0]   req_slot_handle,
   output logic                  rsp_strobe,
   output logic [SLOT_OUT_W-1:0] rsp_granted_slot,
   output logic [COUNT_W-1:0]    rsp_block_size,
   output logic                  rsp_reused,
   output logic [STATUS_W-1:0]   rsp_status
);

   localparam int LG_RAW_W = GRP_W + 4;

   function automatic logic [3:0] bitlen8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         if (v[i]) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

   slot_entry_type slot_mem [SLOT_COUNT];
   slot_entry_type rd_data_ff;
   logic [SLOT_COUNT-1:0] exists_ff;
   logic [SLOT_COUNT-1:0] in_use_ff;

   logic                  action_ff;
   logic [DEV_W-1:0]      dev_ff;
   logic [TYPE_W-1:0]     typ_ff;
   logic [PAD_W-1:0]      m_ff;
   logic [HANDLE_W-1:0]   handle_ff;
   logic [GRP_W-1:0]      grp_ff;
   logic [LOG2_W-1:0]     lg_ff;
   logic [SLOT_IDX_W-1:0] scan_idx_ff;
   logic [SLOT_IDX_W-1:0] cmp_idx_ff;
   logic                  cmp_valid_ff;
   logic                  reuse_found_ff;
   logic [SLOT_IDX_W-1:0] reuse_idx_ff;
   logic                  empty_found_ff;
   logic [SLOT_IDX_W-1:0] empty_idx_ff;

   logic                  rsp_strobe_ff;
   logic [SLOT_OUT_W-1:0] granted_ff;
   logic [COUNT_W-1:0]    size_ff;
   logic                  reused_ff;
   logic [STATUS_W-1:0]   status_ff;

   logic [7:0]            group_bits;
   logic                  group_hit;
   logic [LG_RAW_W-1:0]   lg_raw;
   logic [LOG2_W-1:0]     lg_in;
   logic [SLOT_IDX_W-1:0] handle_idx;
   logic [SLOT_IDX_W-1:0] rd_addr;
   logic                  handle_in_range;
   logic                  reuse_match;
   logic                  mem_we;
   slot_entry_type        mem_wdata;

   assign group_bits = m_ff[{grp_ff, 3'b000} +: 8];
   assign group_hit  = (group_bits != 8'd0);
   assign lg_raw     = LG_RAW_W'({grp_ff, 3'b000}) + LG_RAW_W'(bitlen8(group_bits));

   always_comb begin
      if (lg_raw < LG_RAW_W'(1)) begin
         lg_in = LOG2_W'(1);
      end else if (lg_raw > LG_RAW_W'(MAX_SIZE_LOG2)) begin
         lg_in = LOG2_W'(MAX_SIZE_LOG2);
      end else begin
         lg_in = LOG2_W'(lg_raw);
      end
   end

   assign handle_idx      = SLOT_IDX_W'(handle_ff);
   assign handle_in_range = ({{(32 - HANDLE_W){1'b0}}, handle_ff} < 32'(SLOT_COUNT));
   assign rd_addr         = cmd.ret_read ? handle_idx : scan_idx_ff;

   assign reuse_match = exists_ff[cmp_idx_ff] && !in_use_ff[cmp_idx_ff] &&
                        (rd_data_ff.device == dev_ff) &&
                        (rd_data_ff.elem_type == typ_ff) &&
                        (rd_data_ff.size_log2 == lg_ff);

   assign mem_we    = cmd.req_commit && !reuse_found_ff && empty_found_ff;
   assign mem_wdata = '{device: dev_ff, elem_type: typ_ff, size_log2: lg_ff};

   assign status.is_return  = (action_ff == ACT_RETURN);
   assign status.round_done = group_hit || (grp_ff == '0);
   assign status.scan_last  = (scan_idx_ff == SLOT_IDX_W'(SLOT_COUNT - 1));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[empty_idx_ff] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         dev_ff    <= req_device_kind;
         typ_ff    <= req_element_type;
         handle_ff <= req_slot_handle;
         if (req_element_count == '0) begin
            m_ff <= '0;
         end else begin
            m_ff <= PAD_W'(req_element_count - COUNT_W'(1));
         end
         grp_ff      <= GRP_W'(GROUP_COUNT - 1);
         scan_idx_ff <= '0;
      end else begin
         if (cmd.round_step) begin
            if (group_hit || (grp_ff == '0)) begin
               lg_ff <= lg_in;
            end else begin
               grp_ff <= grp_ff - GRP_W'(1);
            end
         end
         if (cmd.scan_issue) begin
            scan_idx_ff <= scan_idx_ff + SLOT_IDX_W'(1);
         end
      end
      cmp_idx_ff <= scan_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exists_ff      <= '0;
         in_use_ff      <= '0;
         cmp_valid_ff   <= 1'b0;
         reuse_found_ff <= 1'b0;
         empty_found_ff <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         cmp_valid_ff  <= cmd.scan_issue;
         rsp_strobe_ff <= cmd.req_commit || cmd.ret_commit;
         if (cmd.load) begin
            reuse_found_ff <= 1'b0;
            empty_found_ff <= 1'b0;
         end else if (cmp_valid_ff) begin
            if (!reuse_found_ff && reuse_match) begin
               reuse_found_ff <= 1'b1;
               reuse_idx_ff   <= cmp_idx_ff;
            end
            if (!empty_found_ff && !exists_ff[cmp_idx_ff]) begin
               empty_found_ff <= 1'b1;
               empty_idx_ff   <= cmp_idx_ff;
            end
         end
         if (cmd.req_commit) begin
            if (reuse_found_ff) begin
               in_use_ff[reuse_idx_ff] <= 1'b1;
            end else if (empty_found_ff) begin
               exists_ff[empty_idx_ff] <= 1'b1;
               in_use_ff[empty_idx_ff] <= 1'b1;
            end
         end
         if (cmd.ret_commit && handle_in_range && exists_ff[handle_idx] &&
             in_use_ff[handle_idx]) begin
            in_use_ff[handle_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_commit) begin
         priority if (reuse_found_ff) begin
            granted_ff <= SLOT_OUT_W'(reuse_idx_ff);
            size_ff    <= COUNT_W'(1) << lg_ff;
            reused_ff  <= 1'b1;
            status_ff  <= ST_OK;
         end else if (empty_found_ff) begin
            granted_ff <= SLOT_OUT_W'(empty_idx_ff);
            size_ff    <= COUNT_W'(1) << lg_ff;
            reused_ff  <= 1'b0;
            status_ff  <= ST_OK;
         end else begin
            granted_ff <= '0;
            size_ff    <= '0;
            reused_ff  <= 1'b0;
            status_ff  <= ST_FULL;
         end
      end else if (cmd.ret_commit) begin
         if (handle_in_range && exists_ff[handle_idx] && in_use_ff[handle_idx]) begin
            granted_ff <= SLOT_OUT_W'(handle_idx);
            size_ff    <= COUNT_W'(1) << rd_data_ff.size_log2;
            reused_ff  <= 1'b0;
            status_ff  <= ST_OK;
         end else begin
            granted_ff <= '0;
            size_ff    <= '0;
            reused_ff  <= 1'b0;
            status_ff  <= ST_NOT_IN_USE;
         end
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_granted_slot = granted_ff;
   assign rsp_block_size   = size_ff;
   assign rsp_reused       = reused_ff;
   assign rsp_status       = status_ff;

endmodule

// File: src/size_class_block_pool.sv
// Power-of-two block pool with exact-fit reuse over a table of sixteen slots.
// Input channel: a beat is taken at a rising edge where start is high and busy
// is low. A request carries device, data type and element count; a return
// carries the slot handle. The action bit chooses between the two.
// Result channel: each beat appears for one cycle with rsp_strobe high and
// carries the slot, the block size, the reuse flag and a status code.
// A request first rounds the count, stepping from the top byte of the count
// down to the first nonzero byte, then scans the table slot by slot through
// its single read port, then waits for the last read, decides and registers
// the result. A return reads the slot of its handle and registers the result.
// Busy falls as the strobe rises, so the next beat can be taken at the edge
// that ends the strobe cycle; a new beat is not taken while one is in work.
// Synchronous reset empties the table and drops busy and the strobe.
// The receiver cannot stall, so every result is delivered on its strobe.
module size_class_block_pool
   import scbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_action,
   input  logic [DEV_W-1:0]      req_device_kind,
   input  logic [TYPE_W-1:0]     req_element_type,
   input  logic [COUNT_W-1:0]    req_element_count,
   input  logic [HANDLE_W-1:0]   req_slot_handle,
   output logic                  rsp_strobe,
   output logic [SLOT_OUT_W-1:0] rsp_granted_slot,
   output logic [COUNT_W-1:0]    rsp_block_size,
   output logic                  rsp_reused,
   output logic [STATUS_W-1:0]   rsp_status
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   scbp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   scbp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_device_kind   (req_device_kind),
      .req_element_type  (req_element_type),
      .req_element_count (req_element_count),
      .req_slot_handle   (req_slot_handle),
      .rsp_strobe        (rsp_strobe),
      .rsp_granted_slot  (rsp_granted_slot),
      .rsp_block_size    (rsp_block_size),
      .rsp_reused        (rsp_reused),
      .rsp_status        (rsp_status)
   );

endmodule

// File: tb/sv/size_class_block_pool_test.sv
module size_class_block_pool_test;
   timeunit 1ns;
   timeprecision 1ps;
   import scbp_pkg::*;

   typedef struct packed {
      logic                action;
      logic [DEV_W-1:0]    dev;
      logic [TYPE_W-1:0]   etype;
      logic [COUNT_W-1:0]  count;
      logic [HANDLE_W-1:0] handle;
   } pool_cmd_t;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0] slot;
      logic [COUNT_W-1:0]    size;
      logic                  reused;
      logic [STATUS_W-1:0]   status;
   } pool_grant_t;

   typedef struct packed {
      pool_cmd_t   cmd;
      logic        fixed;
      pool_grant_t grant;
   } directed_row_t;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 30;
   localparam int RANDOM_PER_PHASE = 550;
   localparam logic [COUNT_W-1:0] TOP_SIZE = COUNT_W'(1) << MAX_SIZE_LOG2;
   localparam pool_grant_t NO_GRANT = '0;
   localparam pool_grant_t BAD_RETURN = '{4'd0, 25'd0, 1'b0, ST_NOT_IN_USE};
   localparam pool_grant_t TABLE_FULL = '{4'd0, 25'd0, 1'b0, ST_FULL};

   // Rows with a typed grant check a value that follows directly from the
   // rules; the rest are checked against the table model below.
   localparam directed_row_t DIRECTED [25] = '{
      '{'{ACT_RETURN,  2'd0, 4'd0,  25'd0,        4'd0},  1'b1, BAD_RETURN},
      '{'{ACT_REQUEST, 2'd0, 4'd0,  25'd0,        4'd0},  1'b1,
        '{4'd0, 25'd2, 1'b0, ST_OK}},
      '{'{ACT_REQUEST, 2'd3, 4'd15, 25'd1,        4'd15}, 1'b1,
        '{4'd1, 25'd2, 1'b0, ST_OK}},
      '{'{ACT_REQUEST, 2'd1, 4'd5,  25'd2,        4'd0},  1'b1,
        '{4'd2, 25'd2, 1'b0, ST_OK}},
      '{'{ACT_REQUEST, 2'd2, 4'd10, 25'd3,        4'd0},  1'b1,
        '{4'd3, 25'd4, 1'b0, ST_OK}},
      '{'{ACT_REQUEST, 2'd0, 4'd1,  25'd16777216, 4'd0},  1'b1,
        '{4'd4, TOP_SIZE, 1'b0, ST_OK}},
      '{'{ACT_REQUEST, 2'd0, 4'd1,  25'h1FFFFFF,  4'd0},  1'b1,
        '{4'd5, TOP_SIZE, 1'b0, ST_OK}},
      '{'{ACT_RETURN,  2'd3, 4'd15, 25'h1FFFFFF,  4'd0},  1'b1,
        '{4'd0, 25'd2, 1'b0, ST_OK}},
      '{'{ACT_REQUEST, 2'd0, 4'd0,  25'd1,        4'd0},  1'b1,
        '{4'd0, 25'd2, 1'b1, ST_OK}},
      '{'{ACT_RETURN,  2'd0, 4'd0,  25'd0,        4'd5},  1'b1,
        '{4'd5, TOP_SIZE, 1'b0, ST_OK}},
      '{'{ACT_REQUEST, 2'd0, 4'd1,  25'd9000000,  4'd0},  1'b0, NO_GRANT},
      '{'{ACT_RETURN,  2'd0, 4'd0,  25'd0,        4'd3},  1'b0, NO_GRANT},
      '{'{ACT_RETURN,  2'd0, 4'd0,  25'd0,        4'd3},  1'b1, BAD_RETURN},
      '{'{ACT_REQUEST, 2'd2, 4'd11, 25'd4,        4'd0},  1'b0, NO_GRANT},
      '{'{ACT_REQUEST, 2'd1, 4'd2,  25'd5,        4'd9},  1'b0, NO_GRANT},
      '{'{ACT_REQUEST, 2'd2, 4'd3,  25'd17,       4'd0},  1'b0, NO_GRANT},
      '{'{ACT_REQUEST, 2'd3, 4'd4,  25'd100,      4'd0},  1'b0, NO_GRANT},
      '{'{ACT_REQUEST, 2'd0, 4'd6,  25'd1000,     4'd0},  1'b0, NO_GRANT},
      '{'{ACT_REQUEST, 2'd1, 4'd7,  25'd65537,    4'd6},  1'b0, NO_GRANT},
      '{'{ACT_REQUEST, 2'd2, 4'd8,  25'd1048575,  4'd0},  1'b0, NO_GRANT},
      '{'{ACT_REQUEST, 2'd3, 4'd9,  25'd6,        4'd0},  1'b0, NO_GRANT},
      '{'{ACT_REQUEST, 2'd0, 4'd12, 25'd7,        4'd0},  1'b0, NO_GRANT},
      '{'{ACT_REQUEST, 2'd1, 4'd14, 25'd300,      4'd0},  1'b1,
        '{4'd15, 25'd512, 1'b0, ST_OK}},
      '{'{ACT_REQUEST, 2'd3, 4'd13, 25'd64,       4'd0},  1'b1, TABLE_FULL},
      '{'{ACT_REQUEST, 2'd2, 4'd10, 25'd4,        4'd0},  1'b1,
        '{4'd3, 25'd4, 1'b1, ST_OK}}
   };

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_action;
   logic [DEV_W-1:0]      req_device_kind;
   logic [TYPE_W-1:0]     req_element_type;
   logic [COUNT_W-1:0]    req_element_count;
   logic [HANDLE_W-1:0]   req_slot_handle;
   logic                  rsp_strobe;
   logic [SLOT_OUT_W-1:0] rsp_granted_slot;
   logic [COUNT_W-1:0]    rsp_block_size;
   logic                  rsp_reused;
   logic [STATUS_W-1:0]   rsp_status;

   logic              pool_exists [SLOT_COUNT] = '{default: 1'b0};
   logic              pool_taken [SLOT_COUNT] = '{default: 1'b0};
   logic [DEV_W-1:0]  pool_dev [SLOT_COUNT];
   logic [TYPE_W-1:0] pool_etype [SLOT_COUNT];
   logic [LOG2_W-1:0] pool_log2 [SLOT_COUNT];

   pool_grant_t grant_queue [$];
   int mismatches = 0;
   int cycles = 0;
   int n_reused = 0;
   int n_created = 0;
   int n_full = 0;
   int n_freed = 0;
   int n_bad_return = 0;

   size_class_block_pool dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_device_kind   (req_device_kind),
      .req_element_type  (req_element_type),
      .req_element_count (req_element_count),
      .req_slot_handle   (req_slot_handle),
      .rsp_strobe        (rsp_strobe),
      .rsp_granted_slot  (rsp_granted_slot),
      .rsp_block_size    (rsp_block_size),
      .rsp_reused        (rsp_reused),
      .rsp_status        (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic pool_grant_t pool_outcome(input pool_cmd_t c);
      pool_grant_t g;
      logic [LOG2_W-1:0] lg;
      int pick;
      g = '0;
      pick = -1;
      if (c.action == ACT_RETURN) begin
         if (c.handle < SLOT_COUNT && pool_exists[c.handle] && pool_taken[c.handle]) begin
            pool_taken[c.handle] = 1'b0;
            g.slot = SLOT_OUT_W'(c.handle);
            g.size = COUNT_W'(1) << pool_log2[c.handle];
            g.status = ST_OK;
            n_freed++;
         end else begin
            g.status = ST_NOT_IN_USE;
            n_bad_return++;
         end
         return g;
      end
      lg = 1;
      while (lg < MAX_SIZE_LOG2 && (64'd1 << lg) < 64'(c.count))
         lg++;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (pick < 0 && pool_exists[i] && !pool_taken[i] && pool_dev[i] == c.dev &&
             pool_etype[i] == c.etype && pool_log2[i] == lg)
            pick = i;
      end
      if (pick >= 0) begin
         pool_taken[pick] = 1'b1;
         g = '{SLOT_OUT_W'(pick), COUNT_W'(1) << lg, 1'b1, ST_OK};
         n_reused++;
         return g;
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (pick < 0 && !pool_exists[i])
            pick = i;
      end
      if (pick >= 0) begin
         pool_exists[pick] = 1'b1;
         pool_taken[pick] = 1'b1;
         pool_dev[pick] = c.dev;
         pool_etype[pick] = c.etype;
         pool_log2[pick] = lg;
         g = '{SLOT_OUT_W'(pick), COUNT_W'(1) << lg, 1'b0, ST_OK};
         n_created++;
      end else begin
         g.status = ST_FULL;
         n_full++;
      end
      return g;
   endfunction

   // Mostly returns of held blocks and requests that can hit an idle block,
   // with fully random beats mixed in.
   function automatic pool_cmd_t random_cmd();
      pool_cmd_t c;
      logic [LOG2_W-1:0] lg;
      int held [$];
      int made [$];
      int roll;
      int s;
      c.action = 1'($urandom_range(1));
      c.dev = DEV_W'($urandom);
      c.etype = TYPE_W'($urandom);
      c.count = COUNT_W'($urandom);
      c.handle = HANDLE_W'($urandom);
      roll = $urandom_range(99);
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (pool_taken[i])
            held.push_back(i);
         if (pool_exists[i])
            made.push_back(i);
      end
      if (c.action == ACT_RETURN) begin
         if (roll < 80 && held.size() > 0)
            c.handle = HANDLE_W'(held[$urandom_range(held.size() - 1)]);
         return c;
      end
      if (roll < 10)
         return c;
      if (roll < 50 && made.size() > 0) begin
         s = made[$urandom_range(made.size() - 1)];
         c.dev = pool_dev[s];
         c.etype = pool_etype[s];
         lg = pool_log2[s];
      end else if (roll < 58) begin
         lg = LOG2_W'($urandom_range(5, MAX_SIZE_LOG2));
      end else begin
         c.etype = TYPE_W'($urandom_range(1));
         lg = LOG2_W'($urandom_range(1, 4));
      end
      if (lg == 1)
         c.count = COUNT_W'($urandom_range(2));
      else if (lg == MAX_SIZE_LOG2 && $urandom_range(1) == 1)
         c.count = COUNT_W'($urandom_range(32'h1FFFFFF, 32'h1000000));
      else
         c.count = COUNT_W'($urandom_range((1 << (lg - 1)) + 1, 1 << lg));
      return c;
   endfunction

   task automatic issue(input pool_cmd_t c, input logic fixed, input pool_grant_t typed,
                        input int idle_pct);
      pool_grant_t g;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= c.action;
      req_device_kind <= c.dev;
      req_element_type <= c.etype;
      req_element_count <= c.count;
      req_slot_handle <= c.handle;
      do @(posedge clock); while (busy);
      g = pool_outcome(c);
      grant_queue.push_back(fixed ? typed : g);
   endtask

   task automatic note_mismatch(input string what, input pool_grant_t want,
                                input pool_grant_t got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected slot %0d size %0d reused %0d status %0d, got slot %0d size %0d reused %0d status %0d",
                  $realtime, what, want.slot, want.size, want.reused, want.status,
                  got.slot, got.size, got.reused, got.status);
   endtask

   always @(posedge clock) begin
      pool_grant_t want;
      pool_grant_t got;
      got = '{rsp_granted_slot, rsp_block_size, rsp_reused, rsp_status};
      if (!reset && rsp_strobe) begin
         if (grant_queue.size() == 0) begin
            note_mismatch("result beat with nothing outstanding", NO_GRANT, got);
         end else begin
            want = grant_queue.pop_front();
            if (got.slot !== want.slot || got.size !== want.size ||
                got.reused !== want.reused || got.status !== want.status)
               note_mismatch("result beat mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycles, grant_queue.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int idle_phase [3] = '{76, 0, 25};
      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_REQUEST;
      req_device_kind = '0;
      req_element_type = '0;
      req_element_count = '0;
      req_slot_handle = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED[r])
         issue(DIRECTED[r].cmd, DIRECTED[r].fixed, DIRECTED[r].grant, 0);
      foreach (idle_phase[p]) begin
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            issue(random_cmd(), 1'b0, NO_GRANT, idle_phase[p]);
      end
      start <= 1'b0;
      while (grant_queue.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (grant_queue.size() > 0) begin
         mismatches += grant_queue.size();
         $display("%0d expected results never arrived.", grant_queue.size());
      end
      $display("Requests: %0d reused, %0d new blocks, %0d table full.",
               n_reused, n_created, n_full);
      $display("Returns: %0d freed, %0d not in use; %0d mismatches over %0d cycles.",
               n_freed, n_bad_return, mismatches, cycles);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
src/scbp_pkg.sv
src/scbp_ctrl.sv
src/scbp_datapath.sv
src/size_class_block_pool.sv
tb/sv/size_class_block_pool_test.sv
